// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the rasterizer modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold whenever a trigger is true.
`define ASSERT_IMPLY(name, trig, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) else $error(msg);

`endif

// ===== hdl/bfl_pkg.sv =====
// Shared types, constants and pen helpers for the fat line rasterizer.
// No dependencies; bfl_front, bfl_back, the top and the testbench import this package.
package bfl_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int FRAME_BITS         = 13;
    localparam logic [FRAME_BITS-1:0] FRAME_RESET = 13'd4096;

    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam int VALUE_BITS  = 8;
    localparam int QUEUE_DEPTH = 4;

    // The pen covers offsets -3..3, kept here as indexes 0..6.
    localparam int PEN_BITS = 3;
    localparam int PEN_SPAN = 7;
    typedef logic [PEN_BITS-1:0] pen_idx_t;
    localparam pen_idx_t PEN_FIRST  = 3'd0;
    localparam pen_idx_t PEN_CENTER = 3'd3;
    localparam pen_idx_t PEN_LAST   = 3'd6;

    // One stamp as it travels from the front to the back.
    typedef struct packed {
        logic                  blank;
        logic                  done;
        logic                  fat;
        logic [VALUE_BITS-1:0] value;
        pen_idx_t              row_first;
        pen_idx_t              row_last;
        pen_idx_t              col_first;
        pen_idx_t              col_last;
    } stamp_ctl_t;

    localparam int STAMP_CTL_BITS = $bits(stamp_ctl_t);

    // The top and bottom rows of the fat pen lose their corner pixels.
    function automatic logic pen_edge_row(input logic fat, input pen_idx_t row);
        return fat && (row == PEN_FIRST || row == PEN_LAST);
    endfunction

    function automatic pen_idx_t pen_col_lo(input logic fat, input pen_idx_t row,
                                            input pen_idx_t col_first);
        pen_idx_t lo;
        lo = col_first;
        if (pen_edge_row(fat, row) && col_first == PEN_FIRST)
            lo = PEN_FIRST + 3'd1;
        return lo;
    endfunction

    function automatic pen_idx_t pen_col_hi(input logic fat, input pen_idx_t row,
                                            input pen_idx_t col_last);
        pen_idx_t hi;
        hi = col_last;
        if (pen_edge_row(fat, row) && col_last == PEN_LAST)
            hi = PEN_LAST - 3'd1;
        return hi;
    endfunction

endpackage

// ===== hdl/bfl_queue.sv =====
// Small register queue that carries stamps from the front to the back.
// Depends on assert_macros.svh only.
`include "assert_macros.svh"

module bfl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign valid     = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `ASSERT_ALWAYS(a_queue_count_bound, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `ASSERT_IMPLY(a_queue_ptr_match, count_reg == '0 || count_reg == CNT_W'(DEPTH), wr_ptr_reg == rd_ptr_reg, "queue pointers disagree with count")

endmodule

// ===== hdl/bfl_front.sv =====
// Front of the rasterizer: frame registers, line setup and the Bresenham walk.
// Depends on bfl_pkg and assert_macros.svh; feeds stamps to bfl_queue.
`include "assert_macros.svh"

module bfl_front
    import bfl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      kind,
    input  logic [COORD_BITS-1:0]     start_x,
    input  logic [COORD_BITS-1:0]     start_y,
    input  logic [COORD_BITS-1:0]     end_x,
    input  logic [COORD_BITS-1:0]     end_y,
    input  logic                      fat,
    input  logic [VALUE_BITS-1:0]     fill_value,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FRAME_BITS-1:0]     cfg_data,
    output logic                      q_push,
    output stamp_ctl_t                q_ctl,
    output logic [COORD_BITS-1:0]     q_px,
    output logic [COORD_BITS-1:0]     q_py
);

    localparam int ERR_W = COORD_BITS + 2;
    localparam int CMP_W = (COORD_BITS + 2 > FRAME_BITS + 1) ? COORD_BITS + 2 : FRAME_BITS + 1;

    logic [FRAME_BITS-1:0] frame_width_reg, frame_height_reg;

    logic [COORD_BITS-1:0] major_pos_reg, major_pos_next;
    logic [COORD_BITS-1:0] minor_pos_reg, minor_pos_next;
    logic [COORD_BITS-1:0] major_end_reg, major_end_next;
    logic [COORD_BITS-1:0] delta_major_reg, delta_major_next;
    logic [COORD_BITS-1:0] delta_minor_reg, delta_minor_next;
    logic [ERR_W-1:0]      error_acc_reg, error_acc_next;
    logic                  minor_down_reg, minor_down_next;
    logic                  axes_swapped_reg, axes_swapped_next;
    logic                  fat_pen_reg, fat_pen_next;
    logic [VALUE_BITS-1:0] pen_value_reg, pen_value_next;
    logic                  line_active_reg, line_active_next;

    // Line setup.
    logic [COORD_BITS-1:0] adx, ady;
    logic                  gt_x, gt_y, swap, order;
    logic [COORD_BITS-1:0] a_maj, b_maj, a_min, b_min;
    logic                  minor_rising;

    // Walk and clipping.
    logic                  done;
    logic [ERR_W-1:0]      err_sub, err_add;
    logic [CMP_W-1:0]      vx [PEN_SPAN];
    logic [CMP_W-1:0]      vy [PEN_SPAN];
    logic [PEN_SPAN-1:0]   col_ok, row_in, row_ok;
    logic                  step_in;

    assign step_in = accept && (kind == KIND_STEP);

    always_comb
    begin
        gt_x  = start_x > end_x;
        gt_y  = start_y > end_y;
        adx   = gt_x ? start_x - end_x : end_x - start_x;
        ady   = gt_y ? start_y - end_y : end_y - start_y;
        swap  = ady > adx;
        a_maj = swap ? start_y : start_x;
        b_maj = swap ? end_y : end_x;
        a_min = swap ? start_x : start_y;
        b_min = swap ? end_x : end_y;
        order = swap ? gt_y : gt_x;
        // The minor axis rises only if the ordered start lies strictly below the end.
        if (order)
            minor_rising = swap ? gt_x : gt_y;
        else
            minor_rising = swap ? (end_x > start_x) : (end_y > start_y);
    end

    always_comb
    begin
        done    = major_pos_reg >= major_end_reg;
        q_px    = axes_swapped_reg ? minor_pos_reg : major_pos_reg;
        q_py    = axes_swapped_reg ? major_pos_reg : minor_pos_reg;
        err_sub = error_acc_reg - ERR_W'(delta_minor_reg);
        err_add = err_sub + ERR_W'(delta_major_reg);
    end

    // Pen offsets that land inside the frame; a negative value wraps to a set top bit.
    always_comb
    begin
        for (int i = 0; i < PEN_SPAN; i++)
        begin
            vx[i] = CMP_W'(q_px) + CMP_W'(i) - CMP_W'(PEN_CENTER);
            vy[i] = CMP_W'(q_py) + CMP_W'(i) - CMP_W'(PEN_CENTER);
            col_ok[i] = !vx[i][CMP_W-1] && (vx[i] < (CMP_W'(1) << COORD_BITS))
                        && (vx[i] < CMP_W'(frame_width_reg))
                        && (fat_pen_reg || PEN_BITS'(i) == PEN_CENTER);
            row_in[i] = !vy[i][CMP_W-1] && (vy[i] < (CMP_W'(1) << COORD_BITS))
                        && (vy[i] < CMP_W'(frame_height_reg))
                        && (fat_pen_reg || PEN_BITS'(i) == PEN_CENTER);
        end
        for (int i = 0; i < PEN_SPAN; i++)
        begin
            if (pen_edge_row(fat_pen_reg, PEN_BITS'(i)))
                row_ok[i] = row_in[i] && (|col_ok[PEN_SPAN-2:1]);
            else
                row_ok[i] = row_in[i] && (|col_ok);
        end
    end

    always_comb
    begin
        q_ctl.blank     = !line_active_reg || (row_ok == '0);
        q_ctl.done      = line_active_reg && done;
        q_ctl.fat       = fat_pen_reg;
        q_ctl.value     = pen_value_reg;
        q_ctl.row_first = PEN_FIRST;
        q_ctl.row_last  = PEN_FIRST;
        q_ctl.col_first = PEN_FIRST;
        q_ctl.col_last  = PEN_FIRST;
        for (int i = PEN_SPAN - 1; i >= 0; i--)
        begin
            if (row_ok[i])
                q_ctl.row_first = PEN_BITS'(i);
            if (col_ok[i])
                q_ctl.col_first = PEN_BITS'(i);
        end
        for (int i = 0; i < PEN_SPAN; i++)
        begin
            if (row_ok[i])
                q_ctl.row_last = PEN_BITS'(i);
            if (col_ok[i])
                q_ctl.col_last = PEN_BITS'(i);
        end
    end

    assign q_push = step_in;

    always_comb
    begin
        major_pos_next    = major_pos_reg;
        minor_pos_next    = minor_pos_reg;
        major_end_next    = major_end_reg;
        delta_major_next  = delta_major_reg;
        delta_minor_next  = delta_minor_reg;
        error_acc_next    = error_acc_reg;
        minor_down_next   = minor_down_reg;
        axes_swapped_next = axes_swapped_reg;
        fat_pen_next      = fat_pen_reg;
        pen_value_next    = pen_value_reg;
        line_active_next  = line_active_reg;
        if (accept && kind == KIND_LOAD)
        begin
            axes_swapped_next = swap;
            major_pos_next    = order ? b_maj : a_maj;
            major_end_next    = order ? a_maj : b_maj;
            minor_pos_next    = order ? b_min : a_min;
            delta_major_next  = swap ? ady : adx;
            delta_minor_next  = swap ? adx : ady;
            error_acc_next    = ERR_W'((swap ? ady : adx) >> 1);
            minor_down_next   = !minor_rising;
            fat_pen_next      = fat;
            pen_value_next    = fill_value;
            line_active_next  = 1'b1;
        end
        else if (step_in && line_active_reg)
        begin
            if (err_sub[ERR_W-1])
            begin
                minor_pos_next = minor_down_reg ? minor_pos_reg - 1'b1 : minor_pos_reg + 1'b1;
                error_acc_next = err_add;
            end
            else
                error_acc_next = err_sub;
            if (done)
                line_active_next = 1'b0;
            else
                major_pos_next = major_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_RESET;
            frame_height_reg <= FRAME_RESET;
            major_pos_reg    <= '0;
            minor_pos_reg    <= '0;
            major_end_reg    <= '0;
            delta_major_reg  <= '0;
            delta_minor_reg  <= '0;
            error_acc_reg    <= '0;
            minor_down_reg   <= 1'b0;
            axes_swapped_reg <= 1'b0;
            fat_pen_reg      <= 1'b0;
            pen_value_reg    <= '0;
            line_active_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            major_pos_reg    <= major_pos_next;
            minor_pos_reg    <= minor_pos_next;
            major_end_reg    <= major_end_next;
            delta_major_reg  <= delta_major_next;
            delta_minor_reg  <= delta_minor_next;
            error_acc_reg    <= error_acc_next;
            minor_down_reg   <= minor_down_next;
            axes_swapped_reg <= axes_swapped_next;
            fat_pen_reg      <= fat_pen_next;
            pen_value_reg    <= pen_value_next;
            line_active_reg  <= line_active_next;
        end
    end

    `ASSERT_IMPLY(a_front_line_end, $fell(line_active_reg), $past(step_in), "line ended without a step")
    `ASSERT_IMPLY(a_front_line_start, $rose(line_active_reg), $past(accept && kind == KIND_LOAD), "line started without a load")

endmodule

// ===== hdl/bfl_back.sv =====
// Back of the rasterizer: expands each queued stamp into pixel writes.
// Depends on bfl_pkg and assert_macros.svh; reads stamps from bfl_queue.
`include "assert_macros.svh"

module bfl_back
    import bfl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  stamp_ctl_t            q_ctl,
    input  logic [COORD_BITS-1:0] q_px,
    input  logic [COORD_BITS-1:0] q_py,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic                  write_valid,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [VALUE_BITS-1:0] pixel_value,
    output logic                  line_done,
    output logic                  last
);

    logic                  fresh_reg, fresh_next;
    pen_idx_t              row_reg, row_next;
    pen_idx_t              col_reg, col_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  write_valid_reg;
    logic [COORD_BITS-1:0] pixel_x_reg, pixel_y_reg;
    logic [VALUE_BITS-1:0] pixel_value_reg;
    logic                  line_done_reg, last_reg;

    pen_idx_t              cur_row, cur_col;
    logic                  row_end, is_last, emit;

    always_comb
    begin
        cur_row = fresh_reg ? q_ctl.row_first : row_reg;
        cur_col = fresh_reg ? pen_col_lo(q_ctl.fat, q_ctl.row_first, q_ctl.col_first)
                            : col_reg;
        row_end = cur_col == pen_col_hi(q_ctl.fat, cur_row, q_ctl.col_last);
        is_last = q_ctl.blank || (row_end && cur_row == q_ctl.row_last);
        // The output register takes a new result when it is free or being emptied.
        emit    = q_valid && (!out_valid_reg || pop);
        q_pop   = emit && is_last;
    end

    always_comb
    begin
        fresh_next     = fresh_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !pop;
        if (emit)
        begin
            out_valid_next = 1'b1;
            fresh_next     = is_last;
            if (row_end)
            begin
                row_next = cur_row + 1'b1;
                col_next = pen_col_lo(q_ctl.fat, cur_row + 1'b1, q_ctl.col_first);
            end
            else
            begin
                row_next = cur_row;
                col_next = cur_col + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= 1'b1;
            row_reg       <= PEN_FIRST;
            col_reg       <= PEN_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg     <= fresh_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            write_valid_reg <= !q_ctl.blank;
            pixel_x_reg     <= q_ctl.blank ? '0
                               : q_px + COORD_BITS'(cur_col) - COORD_BITS'(PEN_CENTER);
            pixel_y_reg     <= q_ctl.blank ? '0
                               : q_py + COORD_BITS'(cur_row) - COORD_BITS'(PEN_CENTER);
            pixel_value_reg <= q_ctl.blank ? '0 : q_ctl.value;
            line_done_reg   <= q_ctl.done;
            last_reg        <= is_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign write_valid = write_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_value = pixel_value_reg;
    assign line_done   = line_done_reg;
    assign last        = last_reg;

    `ASSERT_IMPLY(a_back_blank_last, out_valid_reg && !write_valid_reg, last_reg, "empty result not marked last")
    `ASSERT_IMPLY(a_back_stamp_held, !fresh_reg, q_valid, "stamp left the queue mid expansion")

endmodule

// ===== hdl/bresenham_fat_line_raster.sv =====
// Bresenham line rasterizer with a thin or a fat (7x7, corners removed) pen. It imports
// bfl_pkg and is built from bfl_front, bfl_queue and bfl_back. Load items set up a line and
// give no result. Step items are taken one per cycle while the stamp queue (QUEUE_DEPTH
// entries) has room; the front advances the line in that cycle. The back hands out one
// result per cycle while its output is free or popped: a thin step gives one result, a
// fat step one per in-frame pixel (up to 45), and a step with nothing in frame one empty
// result. The expansion counter in the back therefore sets the sustained rate for fat
// lines, and full rises when the queue fills behind it. Results sit in an output register,
// so a waiting result does not stop new work. There is no clearing pass after reset.
module bresenham_fat_line_raster
    import bfl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      kind,
    input  logic [COORD_BITS-1:0]     start_x,
    input  logic [COORD_BITS-1:0]     start_y,
    input  logic [COORD_BITS-1:0]     end_x,
    input  logic [COORD_BITS-1:0]     end_y,
    input  logic                      fat,
    input  logic [VALUE_BITS-1:0]     fill_value,
    output logic                      empty,
    input  logic                      pop,
    output logic                      write_valid,
    output logic [COORD_BITS-1:0]     pixel_x,
    output logic [COORD_BITS-1:0]     pixel_y,
    output logic [VALUE_BITS-1:0]     pixel_value,
    output logic                      line_done,
    output logic                      last,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FRAME_BITS-1:0]     cfg_data
);

    localparam int ENTRY_W = STAMP_CTL_BITS + 2 * COORD_BITS;

    logic                  accept;
    logic                  q_push, q_pop, q_valid;
    stamp_ctl_t            f_ctl, b_ctl;
    logic [COORD_BITS-1:0] f_px, f_py, b_px, b_py;
    logic [ENTRY_W-1:0]    head_data;

    assign accept = push && !full;

    bfl_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (kind),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .fat        (fat),
        .fill_value (fill_value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_push     (q_push),
        .q_ctl      (f_ctl),
        .q_px       (f_px),
        .q_py       (f_py)
    );

    bfl_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_ctl, f_px, f_py}),
        .full      (full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_data (head_data)
    );

    assign b_ctl = head_data[ENTRY_W-1 -: STAMP_CTL_BITS];
    assign b_px  = head_data[2*COORD_BITS-1 -: COORD_BITS];
    assign b_py  = head_data[COORD_BITS-1:0];

    bfl_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ctl       (b_ctl),
        .q_px        (b_px),
        .q_py        (b_py),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .write_valid (write_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_value (pixel_value),
        .line_done   (line_done),
        .last        (last)
    );

endmodule

// ===== test/tb_bresenham_fat_line_raster.sv =====
// Self-checking testbench for bresenham_fat_line_raster: directed and random line loads and
// steps under several frame sizes, with random gaps on both queue sides.
// Depends on bfl_pkg and the bresenham_fat_line_raster RTL.
module tb_bresenham_fat_line_raster;
    import bfl_pkg::*;

    localparam int CB            = COORD_BITS_DEFAULT;
    localparam int COORD_MAX     = (1 << CB) - 1;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 32;

    typedef struct {
        logic                  kind;
        logic [CB-1:0]         start_x;
        logic [CB-1:0]         start_y;
        logic [CB-1:0]         end_x;
        logic [CB-1:0]         end_y;
        logic                  fat;
        logic [VALUE_BITS-1:0] fill_value;
        int                    gap;
        bit                    drain_first;
    } line_item_t;

    typedef struct {
        logic                  wr;
        logic [CB-1:0]         x;
        logic [CB-1:0]         y;
        logic [VALUE_BITS-1:0] value;
        logic                  done;
        logic                  last;
    } pixel_write_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    logic                      kind = KIND_LOAD;
    logic [CB-1:0]             start_x = '0;
    logic [CB-1:0]             start_y = '0;
    logic [CB-1:0]             end_x = '0;
    logic [CB-1:0]             end_y = '0;
    logic                      fat = 1'b0;
    logic [VALUE_BITS-1:0]     fill_value = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic                      write_valid;
    logic [CB-1:0]             pixel_x;
    logic [CB-1:0]             pixel_y;
    logic [VALUE_BITS-1:0]     pixel_value;
    logic                      line_done;
    logic                      last;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [FRAME_BITS-1:0]     cfg_data = '0;

    line_item_t   items_to_send[$];
    pixel_write_t writes_due[$];
    line_item_t   sending;
    int           gap_count = 0;
    int           stall_left = 0;
    int           max_gap = 14;
    int           max_stall = 14;
    int           idle_cycles = 0;

    // Predictor copy of the rasterizer state and frame size.
    logic [FRAME_BITS-1:0] frame_w = FRAME_RESET;
    logic [FRAME_BITS-1:0] frame_h = FRAME_RESET;
    logic [CB-1:0]         cur_major = '0;
    logic [CB-1:0]         cur_minor = '0;
    logic [CB-1:0]         end_major = '0;
    logic [CB-1:0]         run_major = '0;
    logic [CB-1:0]         run_minor = '0;
    logic signed [13:0]    err_term = '0;
    logic                  step_down = 1'b0;
    logic                  steep = 1'b0;
    logic                  wide_pen = 1'b0;
    logic [VALUE_BITS-1:0] ink = '0;
    logic                  drawing = 1'b0;

    int items_queued = 0;
    int items_sent = 0;
    int loads_sent = 0;
    int fat_steps = 0;
    int results_seen = 0;
    int blank_results = 0;
    int frame_settings = 1;
    int mismatches = 0;

    bresenham_fat_line_raster #(
        .COORD_BITS(CB)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .fat        (fat),
        .fill_value (fill_value),
        .empty      (empty),
        .pop        (pop),
        .write_valid(write_valid),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_value(pixel_value),
        .line_done  (line_done),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Computes the pixel writes that one accepted item produces and queues them.
    function automatic void rasterize_item(input line_item_t it);
        logic [CB-1:0] ax, ay, bx, by, tmp, d_x, d_y, cx, cy;
        logic          done_now;
        int            reach, x, y;
        pixel_write_t  stamp[$];
        pixel_write_t  w;
        if (it.kind == KIND_LOAD) begin
            ax = it.start_x;
            ay = it.start_y;
            bx = it.end_x;
            by = it.end_y;
            d_x = (bx > ax) ? bx - ax : ax - bx;
            d_y = (by > ay) ? by - ay : ay - by;
            steep = d_y > d_x;
            if (steep) begin
                tmp = ax; ax = ay; ay = tmp;
                tmp = bx; bx = by; by = tmp;
            end
            if (ax > bx) begin
                tmp = ax; ax = bx; bx = tmp;
                tmp = ay; ay = by; by = tmp;
            end
            run_major = bx - ax;
            run_minor = (by > ay) ? by - ay : ay - by;
            err_term = $signed({2'b00, run_major >> 1});
            step_down = !(ay < by);
            cur_major = ax;
            cur_minor = ay;
            end_major = bx;
            wide_pen = it.fat;
            ink = it.fill_value;
            drawing = 1'b1;
            loads_sent++;
        end else if (!drawing) begin
            w = '{1'b0, '0, '0, '0, 1'b0, 1'b1};
            writes_due.push_back(w);
        end else begin
            done_now = cur_major >= end_major;
            cx = steep ? cur_minor : cur_major;
            cy = steep ? cur_major : cur_minor;
            reach = wide_pen ? 3 : 0;
            for (int ty = -reach; ty <= reach; ty++) begin
                for (int tx = -reach; tx <= reach; tx++) begin
                    // The fat pen has its four corner pixels removed.
                    if ((tx == -3 || tx == 3) && (ty == -3 || ty == 3))
                        continue;
                    x = int'(cx) + tx;
                    y = int'(cy) + ty;
                    if (x >= 0 && y >= 0 && x <= COORD_MAX && y <= COORD_MAX &&
                        x < int'(frame_w) && y < int'(frame_h)) begin
                        w = '{1'b1, x[CB-1:0], y[CB-1:0], ink, done_now, 1'b0};
                        stamp.push_back(w);
                    end
                end
            end
            if (stamp.size() == 0) begin
                w = '{1'b0, '0, '0, '0, done_now, 1'b1};
                writes_due.push_back(w);
            end else begin
                stamp[stamp.size() - 1].last = 1'b1;
                foreach (stamp[i])
                    writes_due.push_back(stamp[i]);
            end
            if (wide_pen)
                fat_steps++;
            err_term = err_term - $signed({2'b00, run_minor});
            if (err_term < 0) begin
                cur_minor = step_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
                err_term = err_term + $signed({2'b00, run_major});
            end
            if (done_now)
                drawing = 1'b0;
            else
                cur_major = cur_major + 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [CB-1:0] clamp_coord(input int v);
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[CB-1:0];
    endfunction

    // Mostly picks points near the frame edges so that clipping is exercised.
    function automatic logic [CB-1:0] pick_coord(input int limit);
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 6);
            1: v = limit - 4 + int'($urandom_range(0, 7));
            2: v = COORD_MAX - int'($urandom_range(0, 6));
            default: v = $urandom_range(0, COORD_MAX);
        endcase
        return clamp_coord(v);
    endfunction

    task automatic add_item(input logic kind_v, input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                            input logic [CB-1:0] ex, input logic [CB-1:0] ey, input logic fat_v,
                            input logic [VALUE_BITS-1:0] value_v, input bit drain);
        line_item_t it;
        it = '{kind_v, sx, sy, ex, ey, fat_v, value_v, $urandom_range(0, max_gap), drain};
        items_to_send.push_back(it);
        items_queued++;
    endtask

    // Step items ignore their payload, so it is random to toggle every bit.
    task automatic add_step();
        add_item(KIND_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                 1'($urandom), VALUE_BITS'($urandom), 1'b0);
    endtask

    task automatic add_random_line(input bit drain);
        logic [CB-1:0] sx, sy, ex, ey;
        int            span, n_steps, dx, dy;
        sx = pick_coord(int'(frame_w));
        sy = pick_coord(int'(frame_h));
        case ($urandom_range(0, 7))
            0: begin
                ex = CB'($urandom);
                ey = CB'($urandom);
            end
            1: begin
                ex = sx;
                ey = sy;
            end
            default: begin
                dx = $urandom_range(0, 40);
                dy = $urandom_range(0, 40);
                ex = clamp_coord(int'(sx) + dx - 20);
                ey = clamp_coord(int'(sy) + dy - 20);
            end
        endcase
        dx = (ex > sx) ? int'(ex - sx) : int'(sx - ex);
        dy = (ey > sy) ? int'(ey - sy) : int'(sy - ey);
        span = ((dx > dy) ? dx : dy) + 1;
        // Short lines run to their end and sometimes one step beyond it.
        n_steps = (span <= 16) ? span + int'($urandom_range(0, 1)) : $urandom_range(1, 16);
        add_item(KIND_LOAD, sx, sy, ex, ey, 1'($urandom), VALUE_BITS'($urandom), drain);
        repeat (n_steps)
            add_step();
    endtask

    task automatic wait_until_drained();
        while (items_to_send.size() != 0 || push || writes_due.size() != 0)
            @(posedge clk);
        // Loads give no result, so leave the block time to finish one.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame(input logic [FRAME_BITS-1:0] w, input logic [FRAME_BITS-1:0] h);
        cfg_we <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        frame_w = w;
        frame_h = h;
        frame_settings++;
    endtask

    always @(posedge clk or negedge rst_n) begin : drive_items
        line_item_t nxt;
        bit         holding;
        if (!rst_n) begin
            push <= 1'b0;
            gap_count <= 0;
        end else begin
            holding = push && full;
            if (push && !full) begin
                rasterize_item(sending);
                items_sent++;
            end
            if (!holding) begin
                if (items_to_send.size() == 0 ||
                    (items_to_send[0].drain_first && writes_due.size() != 0)) begin
                    push <= 1'b0;
                end else if (gap_count < items_to_send[0].gap) begin
                    gap_count <= gap_count + 1;
                    push <= 1'b0;
                end else begin
                    nxt = items_to_send.pop_front();
                    sending <= nxt;
                    kind <= nxt.kind;
                    start_x <= nxt.start_x;
                    start_y <= nxt.start_y;
                    end_x <= nxt.end_x;
                    end_y <= nxt.end_y;
                    fat <= nxt.fat;
                    fill_value <= nxt.fill_value;
                    push <= 1'b1;
                    gap_count <= 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : check_writes
        pixel_write_t want;
        int           stall;
        if (!rst_n) begin
            pop <= 1'b0;
            stall_left <= 0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (!write_valid)
                    blank_results++;
                if (writes_due.size() == 0) begin
                    $error("result with no expectation waiting: x=%0d y=%0d", pixel_x, pixel_y);
                    mismatches++;
                end else begin
                    want = writes_due.pop_front();
                    check_field("write_valid", 32'(want.wr), 32'(write_valid));
                    check_field("pixel_x", 32'(want.x), 32'(pixel_x));
                    check_field("pixel_y", 32'(want.y), 32'(pixel_y));
                    check_field("pixel_value", 32'(want.value), 32'(pixel_value));
                    check_field("line_done", 32'(want.done), 32'(line_done));
                    check_field("last", 32'(want.last), 32'(last));
                end
                stall = $urandom_range(0, max_stall);
                pop <= (stall == 0);
                stall_left <= (stall == 0) ? 0 : stall - 1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : run_test
        logic [FRAME_BITS-1:0] rw, rh;
        int                    phase_start;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset frame size.
        add_step();
        add_item(KIND_LOAD, 0, 0, 0, 0, 1'b1, 8'hFF, 1'b0);
        add_step();
        add_step();
        add_item(KIND_LOAD, CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX - 2),
                 CB'(COORD_MAX - 6), 1'b1, 8'h00, 1'b0);
        repeat (3) add_step();
        add_item(KIND_LOAD, 10, 20, 16, 17, 1'b0, 8'h5A, 1'b0);
        repeat (7) add_step();
        add_item(KIND_LOAD, 3000, 100, 2990, 130, 1'b1, 8'hA5, 1'b0);
        repeat (2) add_step();
        add_item(KIND_LOAD, CB'(COORD_MAX), 0, 0, CB'(COORD_MAX), 1'b0, 8'h3C, 1'b1);
        repeat (2) add_step();
        wait_until_drained();

        // A one-pixel frame: fat stamps mostly clip, and a distant one lands nowhere.
        write_frame(1, 1);
        add_item(KIND_LOAD, 0, 0, 3, 0, 1'b1, 8'h81, 1'b0);
        repeat (4) add_step();
        add_item(KIND_LOAD, 100, 100, 100, 100, 1'b1, 8'h7E, 1'b0);
        add_step();
        wait_until_drained();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin rw = 4096; rh = 4096; max_gap = 14; max_stall = 14; end
                1: begin rw = 64;   rh = 48;   max_gap = 0;  max_stall = 0;  end
                2: begin rw = 1;    rh = 8191; max_gap = 14; max_stall = 14; end
                3: begin rw = 8191; rh = 1;    max_gap = 14; max_stall = 0;  end
                4: begin rw = 0;    rh = 4096; max_gap = 0;  max_stall = 14; end
                default: begin
                    rw = FRAME_BITS'($urandom_range(1, 4096));
                    rh = FRAME_BITS'($urandom_range(1, 4096));
                    max_gap = 14;
                    max_stall = 14;
                end
            endcase
            write_frame(rw, rh);
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0)
                    add_item(1'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                             CB'($urandom), 1'($urandom), VALUE_BITS'($urandom), 1'b0);
                else
                    add_random_line($urandom_range(0, 5) == 0);
            end
            wait_until_drained();
        end

        repeat (20) @(posedge clk);
        $display("Sent %0d items (%0d loads, %0d fat steps) over %0d frame sizes.",
                 items_sent, loads_sent, fat_steps, frame_settings);
        $display("Checked %0d pixel writes, %0d of them empty markers.",
                 results_seen, blank_results);
        if (mismatches == 0 && writes_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bfl_pkg.sv
hdl/bfl_queue.sv
hdl/bfl_front.sv
hdl/bfl_back.sv
hdl/bresenham_fat_line_raster.sv
test/tb_bresenham_fat_line_raster.sv
